@@ hw/rtl/fpo_pkg.sv @@
// ---------------------------------------------------------------------------
// fpo_pkg: shared types and constants for the forced phase oscillator
// Holds the quarter-wave sine table, reset values, arithmetic constants and
// the command and status structs between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package fpo_pkg;

   // Day length and sine table geometry
   localparam int STEPS_PER_DAY    = 500;
   localparam int DAY_W            = $clog2(STEPS_PER_DAY);
   localparam int SINE_TABLE_DEPTH = 1024;
   localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int SINE_J_PROD_W    = 30 + SINE_IDX_W;
   localparam int SINE_W           = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int LIGHT_W     = 9;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUPLING = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIFT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIGHT    = 2'd2;

   // Reset values
   localparam logic [31:0]        COUPLING_RESET = 32'd5468372;
   localparam logic [31:0]        DRIFT_RESET    = 32'd4294967;
   localparam logic [LIGHT_W-1:0] LIGHT_RESET    = 9'd250;
   localparam logic [31:0]        PHASE_RESET    = 32'd1431655765;

   // Forcing angles
   localparam logic [31:0] QUARTER_TURN       = 32'h4000_0000;
   localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

   // Shared multiplier and accumulator widths
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 36;
   localparam int SLOPE_SHIFT = 15;
   localparam logic [PROD_W-1:0] SLOPE_ROUND = PROD_W'(1) << (SLOPE_SHIFT - 1);

   // Divide by three: q = (a * ceil(2^35 / 3)) >> 35, exact for a < 2^34
   localparam int DIV3_SHIFT  = 35;
   localparam int RECIP_SPLIT = 17;
   localparam int QSUM_W      = PROD_W + RECIP_SPLIT;
   localparam logic [63:0] DIV3_RECIP_WIDE = ((64'd1 << DIV3_SHIFT) / 64'd3) + 64'd1;
   localparam logic [MUL_A_W-1:0] DIV3_RECIP = DIV3_RECIP_WIDE[MUL_A_W-1:0];
   localparam logic [MUL_B_W-1:0] RECIP_LO   = DIV3_RECIP[RECIP_SPLIT-1:0];
   localparam logic [MUL_B_W-1:0] RECIP_HI   = DIV3_RECIP[MUL_A_W-1:RECIP_SPLIT];

   // Runge-Kutta stage index
   typedef logic [1:0] stage_type;
   localparam stage_type STAGE_K1 = 2'd0;
   localparam stage_type STAGE_K2 = 2'd1;
   localparam stage_type STAGE_K3 = 2'd2;
   localparam stage_type STAGE_K4 = 2'd3;

   // Sine table build (Taylor series in Q30, evaluated at elaboration)
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TAYLOR_DIV [1:6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                                64'd156};

   typedef logic [SINE_W-1:0] sine_table_type [0:SINE_TABLE_DEPTH];

   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      logic [63:0]    u;
      logic [63:0]    x;
      logic [63:0]    x2;
      logic [63:0]    term;
      logic [63:0]    sum;
      logic [63:0]    v;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         u    = (64'(i) << 30) / 64'(SINE_TABLE_DEPTH);
         x    = (u * HALF_PI_Q30) >> 30;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int n = 1; n <= 6; n++) begin
            term = (term * x2) >> 30;
            term = term / TAYLOR_DIV[n];
            if (n[0]) begin
               sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
               sum = sum + term;
            end
         end
         v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
         if (v > 64'd32767) begin
            v = 64'd32767;
         end
         tbl[i] = v[SINE_W-1:0];
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOK,
      ST_MUL,
      ST_SLOPE,
      ST_DIV_LO,
      ST_DIV_HI,
      ST_QUOT,
      ST_UPD,
      ST_NEW_SINE,
      ST_COMMIT
   } fpo_state_type;

   // Controller to datapath
   typedef struct packed {
      logic      start;
      logic      look;
      logic      mul;
      logic      slope;
      logic      div_lo;
      logic      div_hi;
      logic      quot;
      logic      upd;
      logic      commit;
      stage_type stage;
   } fpo_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic crossed;
      logic out_free;
   } fpo_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/fpo_ctrl.sv @@
// ---------------------------------------------------------------------------
// fpo_ctrl: sequencer for one Runge-Kutta step
// Steps the datapath through four slope evaluations, the divide by six,
// the phase update, the crossing test and the commit of state and result.
// ---------------------------------------------------------------------------
`default_nettype none

module fpo_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_tick,
   output logic                   req_ready,
   input  fpo_pkg::fpo_status_type status,
   output fpo_pkg::fpo_cmd_type    cmd
);
   import fpo_pkg::*;

   fpo_state_type state_ff;
   fpo_state_type state_in;
   stage_type     stage_ff;
   stage_type     stage_in;

   // State and stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stage_ff <= STAGE_K1;
      end else begin
         state_ff <= state_in;
         stage_ff <= stage_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      stage_in  = stage_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.stage = stage_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_tick) begin
               cmd.start = 1'b1;
               stage_in  = STAGE_K1;
               state_in  = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SLOPE;
         end
         ST_SLOPE: begin
            cmd.slope = 1'b1;
            if (stage_ff == STAGE_K4) begin
               state_in = ST_DIV_LO;
            end else begin
               stage_in = stage_ff + 2'd1;
               state_in = ST_LOOK;
            end
         end
         ST_DIV_LO: begin
            cmd.div_lo = 1'b1;
            state_in   = ST_DIV_HI;
         end
         ST_DIV_HI: begin
            cmd.div_hi = 1'b1;
            state_in   = ST_QUOT;
         end
         ST_QUOT: begin
            cmd.quot = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.upd  = 1'b1;
            state_in = ST_NEW_SINE;
         end
         ST_NEW_SINE: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // hold while a crossing result would overwrite an untaken one
            if (!status.crossed || status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/fpo_datapath.sv @@
// ---------------------------------------------------------------------------
// fpo_datapath: oscillator state, sine lookup, shared multiplier, result
// One registered table read and one 34x17 multiplier serve the slope
// evaluations, the divide by six and the crossing test.
// ---------------------------------------------------------------------------
`default_nettype none

module fpo_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  fpo_pkg::fpo_cmd_type                 cmd,
   output fpo_pkg::fpo_status_type              status,
   input  logic                                csr_wr_en,
   input  logic [fpo_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fpo_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [31:0]                         rsp_crossing_step,
   output logic [31:0]                         rsp_span_steps,
   output logic [31:0]                         rsp_prior_span_steps
);
   import fpo_pkg::*;

   // Configuration and oscillator state
   logic [31:0]        coupling_ff, coupling_in;
   logic [31:0]        drift_ff, drift_in;
   logic [LIGHT_W-1:0] light_ff, light_in;
   logic [31:0]        phase_ff, phase_in;
   logic [31:0]        step_ff, step_in;
   logic [DAY_W-1:0]   day_ff, day_in;
   logic [31:0]        last_cross_ff, last_cross_in;
   logic [31:0]        second_cross_ff, second_cross_in;
   logic [31:0]        last_span_ff, last_span_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [31:0]        off_ff, off_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic               k_neg_ff, k_neg_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [PROD_W-1:0]  lo_ff, lo_in;
   logic [31:0]        quot_ff, quot_in;
   logic [31:0]        new_phase_ff, new_phase_in;
   logic [SINE_W-1:0]  rom_ff;
   logic [1:0]         quad_ff;
   logic               old_zero_ff, old_zero_in;
   logic               old_neg_ff, old_neg_in;
   logic [31:0]        rsp_cross_ff, rsp_cross_in;
   logic [31:0]        rsp_span_ff, rsp_span_in;
   logic [31:0]        rsp_prior_ff, rsp_prior_in;

   // Combinational helpers
   logic [31:0]              forcing;
   logic [31:0]              sin_arg;
   logic [SINE_J_PROD_W-1:0] j_prod;
   logic [SINE_IDX_W-1:0]    j_idx;
   logic [SINE_IDX_W-1:0]    rom_addr;
   logic [MUL_A_W-1:0]       mul_a;
   logic [MUL_B_W-1:0]       mul_b;
   logic [PROD_W-1:0]        mul_p;
   logic [PROD_W-1:0]        rounded;
   logic [31:0]              slope_mag;
   logic [31:0]              half_mag;
   logic [ACC_W-1:0]         weighted;
   logic                     weight_two;
   logic [ACC_W-1:0]         acc_mag;
   logic [MUL_A_W-1:0]       div_a;
   logic [QSUM_W-1:0]        q_sum;
   logic [31:0]              total;
   logic                     new_zero;
   logic                     new_neg;
   logic                     crossed;
   logic [31:0]              span;

   // Forcing angle from position in the day
   assign forcing = (32'(day_ff) <= 32'(light_ff)) ? QUARTER_TURN : THREE_QUARTER_TURN;

   // Sine lookup address: quadrant mirror of the quarter-wave table
   always_comb begin
      if (cmd.look) begin
         sin_arg = phase_ff + off_ff - forcing;
      end else if (cmd.div_lo) begin
         sin_arg = phase_ff;
      end else begin
         sin_arg = new_phase_ff;
      end
      j_prod = SINE_J_PROD_W'(sin_arg[29:0]) * SINE_J_PROD_W'(SINE_TABLE_DEPTH);
      j_idx  = j_prod[SINE_J_PROD_W-1:30];
      if (sin_arg[30]) begin
         rom_addr = SINE_IDX_W'(SINE_TABLE_DEPTH) - j_idx;
      end else begin
         rom_addr = j_idx;
      end
   end

   // Shared multiplier: coupling times sine, or divide-by-three halves
   assign acc_mag = acc_ff[ACC_W-1] ? (ACC_W'(0) - acc_ff) : acc_ff;
   assign div_a   = acc_mag[MUL_A_W:1];

   always_comb begin
      if (cmd.mul) begin
         mul_a = MUL_A_W'(coupling_ff);
         mul_b = MUL_B_W'(rom_ff);
      end else if (cmd.div_hi) begin
         mul_a = div_a;
         mul_b = RECIP_HI;
      end else begin
         mul_a = div_a;
         mul_b = RECIP_LO;
      end
      mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // Slope magnitude, weighted sum term and next stage offset
   assign rounded    = prod_ff + SLOPE_ROUND;
   assign slope_mag  = rounded[SLOPE_SHIFT+31:SLOPE_SHIFT];
   assign weight_two = (cmd.stage == STAGE_K2) || (cmd.stage == STAGE_K3);
   assign weighted   = weight_two ? ACC_W'({slope_mag, 1'b0}) : ACC_W'(slope_mag);
   assign half_mag   = (cmd.stage == STAGE_K3) ? slope_mag : {1'b0, slope_mag[31:1]};

   // Quotient and phase update
   assign q_sum = {prod_ff, {RECIP_SPLIT{1'b0}}} + QSUM_W'(lo_ff);
   assign total = acc_ff[ACC_W-1] ? (32'd0 - quot_ff) : quot_ff;

   // Crossing test on the new phase's sine (held in the table register)
   assign new_zero = (rom_ff == '0);
   assign new_neg  = quad_ff[1] && !new_zero;
   assign crossed  = old_zero_ff || new_zero || (old_neg_ff != new_neg);
   assign span     = step_ff - second_cross_ff;

   assign status.crossed  = crossed;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // Next values
   always_comb begin
      coupling_in     = coupling_ff;
      drift_in        = drift_ff;
      light_in        = light_ff;
      phase_in        = phase_ff;
      step_in         = step_ff;
      day_in          = day_ff;
      last_cross_in   = last_cross_ff;
      second_cross_in = second_cross_ff;
      last_span_in    = last_span_ff;
      off_in          = off_ff;
      acc_in          = acc_ff;
      k_neg_in        = k_neg_ff;
      prod_in         = prod_ff;
      lo_in           = lo_ff;
      quot_in         = quot_ff;
      new_phase_in    = new_phase_ff;
      old_zero_in     = old_zero_ff;
      old_neg_in      = old_neg_ff;
      rsp_cross_in    = rsp_cross_ff;
      rsp_span_in     = rsp_span_ff;
      rsp_prior_in    = rsp_prior_ff;

      // configuration writes
      if (csr_wr_en) begin
         case (csr_index)
            CSR_COUPLING: coupling_in = csr_wr_data;
            CSR_DRIFT:    drift_in    = csr_wr_data;
            CSR_LIGHT:    light_in    = csr_wr_data[LIGHT_W-1:0];
            default:      ;
         endcase
      end

      if (cmd.start) begin
         off_in = '0;
         acc_in = '0;
      end

      // slope sign is opposite to the sine sign
      if (cmd.mul) begin
         k_neg_in = !quad_ff[1] && (rom_ff != '0);
      end

      if (cmd.mul || cmd.div_lo || cmd.div_hi) begin
         prod_in = mul_p;
      end

      if (cmd.slope) begin
         acc_in = k_neg_ff ? (acc_ff - weighted) : (acc_ff + weighted);
         off_in = k_neg_ff ? (32'd0 - half_mag) : half_mag;
      end

      // low partial product parked; sine of the old phase is in the table reg
      if (cmd.div_hi) begin
         lo_in       = prod_ff;
         old_zero_in = (rom_ff == '0);
         old_neg_in  = quad_ff[1] && (rom_ff != '0);
      end

      if (cmd.quot) begin
         quot_in = q_sum[DIV3_SHIFT+31:DIV3_SHIFT];
      end

      if (cmd.upd) begin
         new_phase_in = phase_ff + total + drift_ff;
      end

      // commit the step
      if (cmd.commit) begin
         phase_in = new_phase_ff;
         step_in  = step_ff + 32'd1;
         if (day_ff == DAY_W'(STEPS_PER_DAY - 1)) begin
            day_in = '0;
         end else begin
            day_in = day_ff + DAY_W'(1);
         end
         if (crossed) begin
            second_cross_in = last_cross_ff;
            last_cross_in   = step_ff;
            last_span_in    = span;
            rsp_cross_in    = step_ff;
            rsp_span_in     = span;
            rsp_prior_in    = last_span_ff;
         end
      end

      // result valid
      if (cmd.commit && crossed) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         coupling_ff     <= COUPLING_RESET;
         drift_ff        <= DRIFT_RESET;
         light_ff        <= LIGHT_RESET;
         phase_ff        <= PHASE_RESET;
         step_ff         <= '0;
         day_ff          <= '0;
         last_cross_ff   <= '0;
         second_cross_ff <= '0;
         last_span_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         coupling_ff     <= coupling_in;
         drift_ff        <= drift_in;
         light_ff        <= light_in;
         phase_ff        <= phase_in;
         step_ff         <= step_in;
         day_ff          <= day_in;
         last_cross_ff   <= last_cross_in;
         second_cross_ff <= second_cross_in;
         last_span_ff    <= last_span_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Working and payload registers, table read
   always_ff @(posedge clock) begin
      off_ff       <= off_in;
      acc_ff       <= acc_in;
      k_neg_ff     <= k_neg_in;
      prod_ff      <= prod_in;
      lo_ff        <= lo_in;
      quot_ff      <= quot_in;
      new_phase_ff <= new_phase_in;
      old_zero_ff  <= old_zero_in;
      old_neg_ff   <= old_neg_in;
      rsp_cross_ff <= rsp_cross_in;
      rsp_span_ff  <= rsp_span_in;
      rsp_prior_ff <= rsp_prior_in;
      rom_ff       <= SINE_TABLE[rom_addr];
      quad_ff      <= sin_arg[31:30];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_crossing_step    = rsp_cross_ff;
   assign rsp_span_steps       = rsp_span_ff;
   assign rsp_prior_span_steps = rsp_prior_ff;

endmodule

`default_nettype wire

@@ hw/rtl/forced_phase_oscillator_rk4.sv @@
// ---------------------------------------------------------------------------
// forced_phase_oscillator_rk4: RK4 forced phase oscillator with crossings
// Advances a wrapping 32-bit phase one fourth-order Runge-Kutta step per
// tick and reports each sine sign change with the step and span history.
// ---------------------------------------------------------------------------
// A tick item of 1 is accepted while idle and then runs the four slope
// evaluations (each a registered sine-table read, one pass through the
// shared 34x17 multiplier and a slope/accumulate step), two multiplier
// passes for the divide by six, then the quotient, the phase update, the
// new-phase sine read and the commit; no new item is accepted until it
// is done. A tick of 0 is taken while idle and changes nothing. A crossing
// result sits in an output register; the block keeps accepting items, and
// only a commit that would produce a new result waits until the previous
// one is taken. Configuration writes are registered directly and are meant
// for an idle block.
`default_nettype none

module forced_phase_oscillator_rk4 (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_tick,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [31:0]                      rsp_crossing_step,
   output logic [31:0]                      rsp_span_steps,
   output logic [31:0]                      rsp_prior_span_steps,
   input  logic                             csr_wr_en,
   input  logic [fpo_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fpo_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import fpo_pkg::*;

   fpo_cmd_type    cmd;
   fpo_status_type status;

   // Sequencer
   fpo_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_tick  (req_tick),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // State, arithmetic and result register
   fpo_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wr_data          (csr_wr_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_crossing_step    (rsp_crossing_step),
      .rsp_span_steps       (rsp_span_steps),
      .rsp_prior_span_steps (rsp_prior_span_steps)
   );

endmodule

`default_nettype wire

@@ verif/forced_phase_oscillator_rk4_test.sv @@
// ---------------------------------------------------------------------------
// forced_phase_oscillator_rk4_test: self-checking bench for the RK4 oscillator
// Drives tick items through the request channel and register settings through
// the CSR port. A scoreboard steps its own fixed-point RK4 oscillator per
// accepted item and compares every crossing report field by field.
// ---------------------------------------------------------------------------
module forced_phase_oscillator_rk4_test;
   timeunit 1ns;
   timeprecision 1ps;

   import fpo_pkg::CSR_INDEX_W;
   import fpo_pkg::CSR_DATA_W;
   import fpo_pkg::CSR_COUPLING;
   import fpo_pkg::CSR_DRIFT;
   import fpo_pkg::CSR_LIGHT;

   // Oscillator constants
   localparam int          DAY_STEPS   = 500;
   localparam int          LUT_DEPTH   = 1024;
   localparam bit [63:0]   HALF_PI_Q30 = 64'd1686629713;
   localparam bit [31:0]   START_PHASE = 32'd1431655765;
   localparam bit [31:0]   FORCE_LIGHT = 32'h4000_0000;
   localparam bit [31:0]   FORCE_DARK  = 32'hC000_0000;
   localparam bit [31:0]   HALF_TURN   = 32'h8000_0000;
   localparam bit [31:0]   DEF_COUPLE  = 32'd5468372;
   localparam bit [31:0]   DEF_DRIFT   = 32'd4294967;
   localparam bit [8:0]    DEF_LIGHT   = 9'd250;
   localparam bit [8:0]    LIGHT_MAX   = 9'd500;

   // Bench knobs
   localparam int RANDOM_ROUNDS  = 10;
   localparam int ROUND_TICKS    = 188;
   localparam int SETTLE_CYCLES  = 24;
   localparam int IDLE_LIMIT     = 2000;

   typedef struct packed {
      logic [31:0] crossing_step;
      logic [31:0] span_steps;
      logic [31:0] prior_span_steps;
   } crossing_t;

   typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_SPARSE, RX_STALL} rx_mode_e;

   // Scoreboard: own RK4 oscillator plus the queue of predicted crossings
   class crossing_scoreboard;
      bit [31:0]   coupling;
      bit [31:0]   drift;
      bit [8:0]    light;
      bit [31:0]   phase;
      bit [31:0]   step_count;
      bit [8:0]    day_pos;
      bit [31:0]   last_cross;
      bit [31:0]   second_cross;
      bit [31:0]   third_cross;
      bit [31:0]   last_span;
      int          sine_lut [0:LUT_DEPTH];
      crossing_t   pending_crossings [$];
      int unsigned mismatches;
      int unsigned ticks_seen;
      int unsigned crossings_predicted;
      int unsigned results_seen;

      function new();
         coupling   = DEF_COUPLE;
         drift      = DEF_DRIFT;
         light      = DEF_LIGHT;
         phase      = START_PHASE;
         step_count = 0;
         day_pos    = 0;
         last_cross = 0;
         second_cross = 0;
         third_cross  = 0;
         last_span  = 0;
         build_quarter_wave();
      endfunction

      // Quarter-wave table: Taylor series through x^13 in Q30, scaled to Q1.15
      function void build_quarter_wave();
         bit [63:0] x;
         bit [63:0] x_sq;
         bit [63:0] term;
         bit [63:0] acc;
         bit [63:0] q15;
         for (int i = 0; i <= LUT_DEPTH; i++) begin
            x    = ((((64'(i)) << 30) / 64'(LUT_DEPTH)) * HALF_PI_Q30) >> 30;
            x_sq = (x * x) >> 30;
            term = x;
            acc  = x;
            for (int n = 1; n <= 6; n++) begin
               term = ((term * x_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
               if (n % 2 == 1) begin
                  acc = (acc >= term) ? acc - term : 64'd0;
               end else begin
                  acc = acc + term;
               end
            end
            q15 = (acc * 64'd32767 + (64'd1 << 29)) >> 30;
            sine_lut[i] = (q15 > 64'd32767) ? 32767 : int'(q15);
         end
      endfunction

      function int quarter_sine(bit [31:0] p);
         bit [63:0] j;
         int        s;
         j = ({34'd0, p[29:0]} * 64'(LUT_DEPTH)) >> 30;
         if (j > 64'(LUT_DEPTH)) begin
            j = 64'(LUT_DEPTH);
         end
         s = p[30] ? sine_lut[64'(LUT_DEPTH) - j] : sine_lut[j];
         return p[31] ? -s : s;
      endfunction

      // Slope sample: rounded coupling * |sin|, sign opposite to the sine
      function longint slope_at(bit [31:0] arg, bit [31:0] forcing);
         int        s;
         bit [63:0] mag;
         bit [63:0] m;
         s   = quarter_sine(arg - forcing);
         mag = (s < 0) ? 64'(-s) : 64'(s);
         m   = ({32'd0, coupling} * mag + 64'd16384) >> 15;
         return (s > 0) ? -longint'(m) : longint'(m);
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_COUPLING: coupling = value;
            CSR_DRIFT:    drift    = value;
            CSR_LIGHT:    light    = value[8:0];
            default: ;
         endcase
      endfunction

      function bit [31:0] phase_now();
         return phase;
      endfunction

      function int pending();
         return pending_crossings.size();
      endfunction

      // One accepted tick item: RK4 step, then crossing detection
      function void note_tick(logic tick);
         bit [31:0] forcing;
         bit [31:0] prev_phase;
         bit [31:0] arg;
         longint    k1;
         longint    k2;
         longint    k3;
         longint    k4;
         longint    mean;
         int        s_prev;
         int        s_next;
         crossing_t c;
         if (tick !== 1'b1) begin
            return;
         end
         ticks_seen++;
         forcing    = (day_pos <= light) ? FORCE_LIGHT : FORCE_DARK;
         prev_phase = phase;
         k1   = slope_at(phase, forcing);
         arg  = phase + 32'(k1 / 2);
         k2   = slope_at(arg, forcing);
         arg  = phase + 32'(k2 / 2);
         k3   = slope_at(arg, forcing);
         arg  = phase + 32'(k3);
         k4   = slope_at(arg, forcing);
         mean = (k1 + 2 * k2 + 2 * k3 + k4) / 6;
         phase = phase + 32'(mean) + drift;

         s_prev = quarter_sine(prev_phase);
         s_next = quarter_sine(phase);
         if (s_prev == 0 || s_next == 0 || ((s_prev < 0) != (s_next < 0))) begin
            third_cross  = second_cross;
            second_cross = last_cross;
            last_cross   = step_count;
            c.crossing_step    = step_count;
            c.span_steps       = step_count - third_cross;
            c.prior_span_steps = last_span;
            last_span = c.span_steps;
            pending_crossings.push_back(c);
            crossings_predicted++;
         end

         step_count = step_count + 1;
         day_pos    = (day_pos + 9'd1 >= 9'(DAY_STEPS)) ? 9'd0 : day_pos + 9'd1;
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("[%0t] mismatch: %s", $realtime, msg);
      endtask

      // One accepted result item against the oldest prediction
      task check_crossing(crossing_t got);
         crossing_t want;
         results_seen++;
         if (pending_crossings.size() == 0) begin
            report_mismatch($sformatf("crossing at step %0d with none predicted",
                                      got.crossing_step));
            return;
         end
         want = pending_crossings.pop_front();
         if (got.crossing_step !== want.crossing_step) begin
            report_mismatch($sformatf("crossing_step got %0d want %0d",
                                      got.crossing_step, want.crossing_step));
         end
         if (got.span_steps !== want.span_steps) begin
            report_mismatch($sformatf("span_steps at step %0d got %0d want %0d",
                                      want.crossing_step, got.span_steps, want.span_steps));
         end
         if (got.prior_span_steps !== want.prior_span_steps) begin
            report_mismatch($sformatf("prior_span_steps at step %0d got %0d want %0d",
                                      want.crossing_step, got.prior_span_steps,
                                      want.prior_span_steps));
         end
      endtask
   endclass

   // DUT signals; the driven inputs are known from time zero
   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   logic                   req_tick    = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   logic [31:0]            rsp_crossing_step;
   logic [31:0]            rsp_span_steps;
   logic [31:0]            rsp_prior_span_steps;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = CSR_COUPLING;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   crossing_scoreboard sb = new();
   int unsigned        zero_ticks;
   int unsigned        settings_applied;
   int unsigned        idle_cycles;
   rx_mode_e           rx_mode     = RX_FREE;
   int unsigned        rx_mode_left;

   forced_phase_oscillator_rk4 i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_tick             (req_tick),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_crossing_step    (rsp_crossing_step),
      .rsp_span_steps       (rsp_span_steps),
      .rsp_prior_span_steps (rsp_prior_span_steps),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wr_data          (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Monitor both channels at the rising edge; watchdog on lack of progress
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_tick(req_tick);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_crossing(crossing_t'{rsp_crossing_step, rsp_span_steps,
                                          rsp_prior_span_steps});
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Result receiver: switches between free, coin-flip, sparse and long stalls
   always @(negedge clock) begin
      if (rx_mode_left == 0) begin
         rx_mode      <= rx_mode_e'($urandom_range(0, 3));
         rx_mode_left <= $urandom_range(50, 300);
      end else begin
         rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
         RX_FREE:   rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:   rsp_ready <= (rx_mode_left % 32 < 2);
      endcase
   end

   task automatic send_tick(logic tick);
      @(negedge clock);
      req_valid <= 1'b1;
      req_tick  <= tick;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic hold_off(int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Drop valid, drain predictions, then let a silent tick finish
   task automatic settle_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      sb.set_register(idx, value);
   endtask

   task automatic write_setting(logic [31:0] couple, logic [31:0] drift, logic [8:0] light);
      write_register(CSR_COUPLING, couple);
      write_register(CSR_DRIFT, drift);
      write_register(CSR_LIGHT, {23'd0, light});
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_applied++;
   endtask

   task automatic apply_setting(logic [31:0] couple, logic [31:0] drift, logic [8:0] light);
      settle_idle();
      write_setting(couple, drift, light);
   endtask

   // Random setting; lively forces a drift that crosses every few steps
   task automatic pick_setting(bit lively);
      logic [31:0] couple;
      logic [31:0] drift;
      logic [8:0]  light;
      case ($urandom_range(0, 3))
         0:       couple = 32'd0;
         1:       couple = 32'hFFFF_FFFF;
         2:       couple = $urandom_range(0, 32'h0200_0000);
         default: couple = $urandom;
      endcase
      case (lively ? 0 : $urandom_range(0, 4))
         0, 1:    drift = $urandom_range(32'h0400_0000, 32'h3000_0000);
         2:       drift = $urandom;
         3:       drift = DEF_DRIFT;
         default: drift = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
      endcase
      case ($urandom_range(0, 2))
         0:       light = 9'd0;
         1:       light = LIGHT_MAX;
         default: light = 9'($urandom_range(0, 500));
      endcase
      apply_setting(couple, drift, light);
   endtask

   // Bursts of items with random gaps; roughly one in ten is a zero tick
   task automatic run_ticks(int unsigned count);
      int unsigned sent;
      int unsigned burst;
      logic        tick;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         if (burst > count - sent) begin
            burst = count - sent;
         end
         repeat (burst) begin
            tick = ($urandom_range(0, 9) != 0);
            send_tick(tick);
            sent++;
            if (!tick) begin
               zero_ticks++;
            end
         end
         if ($urandom_range(0, 3) != 0) begin
            hold_off($urandom_range(1, 30));
         end
      end
   endtask

   initial begin
      logic [31:0] landing;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: reset setting with zero ticks mixed in
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      zero_ticks += 2;

      // Quarter-turn drift, no coupling: early crossings read zero history
      apply_setting(32'd0, 32'h4000_0000, 9'd0);
      repeat (8) send_tick(1'b1);

      // Full-scale coupling, no drift, light covers the whole day
      apply_setting(32'hFFFF_FFFF, 32'd0, LIGHT_MAX);
      repeat (5) send_tick(1'b1);

      // Full-scale drift steps back one unit per tick
      apply_setting(32'd0, 32'hFFFF_FFFF, 9'd0);
      repeat (3) send_tick(1'b1);

      // Land exactly on a zero of the sine, then sit on it
      settle_idle();
      landing = HALF_TURN - sb.phase_now();
      write_setting(32'd0, landing, 9'd0);
      send_tick(1'b1);
      apply_setting(32'd0, 32'd0, 9'd0);
      send_tick(1'b1);
      send_tick(1'b1);

      // Random rounds, each under a fresh setting; every third one is lively
      for (int r = 0; r < RANDOM_ROUNDS; r++) begin
         pick_setting(r % 3 == 0);
         run_ticks(ROUND_TICKS);
      end

      settle_idle();
      $display("Run covered %0d ticks and %0d zero ticks under %0d register settings.",
               sb.ticks_seen, zero_ticks, settings_applied);
      $display("Crossing reports checked: %0d of %0d predicted, %0d mismatches.",
               sb.results_seen, sb.crossings_predicted, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

@@ sim.f @@
hw/rtl/fpo_pkg.sv
hw/rtl/fpo_ctrl.sv
hw/rtl/fpo_datapath.sv
hw/rtl/forced_phase_oscillator_rk4.sv
verif/forced_phase_oscillator_rk4_test.sv
